// File: hdl/ucfr_pkg.sv
// Shared types and constants for the control fragment reassembler.
`default_nettype none
package ucfr_pkg;
    localparam int HDR_BYTES = 4;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_CONT  = 2'd1,
        MODE_FINAL = 2'd2,
        MODE_DROP  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_WORD   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_BUFFERED = 3'd0,
        ST_ACCEPTED = 3'd1,
        ST_SHORT    = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_MISMATCH = 3'd4,
        ST_TOO_LONG = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        EM_IDLE   = 2'd0,
        EM_HEADER = 2'd1,
        EM_WORDS  = 2'd2
    } emit_state_t;

    // request from the fragment controller to the packet emitter
    typedef struct packed {
        logic       start;
        logic [2:0] msg_type;
        logic [3:0] grp;
        logic [5:0] opc;
    } emit_req_t;
endpackage
`default_nettype wire

// File: hdl/ucfr_store.sv
// Payload byte memory: one write port, one registered read port.
`default_nettype none
module ucfr_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);
    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// File: hdl/ucfr_top_impl.sv
// Packet emitter: reads the payload store and packs result words.
`default_nettype none
module ucfr_emitter #(
    parameter int AW  = 10,
    parameter int LW  = 11,
    parameter int WB  = 8,
    parameter int TDW = 96
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire ucfr_pkg::emit_req_t req,
    input  wire logic [LW-1:0]       total,
    output logic                     busy,
    output logic [AW-1:0]            rd_addr,
    input  wire logic [7:0]          rd_data,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [TDW-1:0]           m_tdata,
    output logic [1:0]               m_tuser,
    output logic                     m_tlast
);
    localparam int NW = (WB > 1) ? $clog2(WB + 1) : 1;
    localparam int SW = (WB > 1) ? $clog2(WB) : 1;

    ucfr_pkg::emit_state_t state_reg, state_next;
    logic [LW-1:0] rd_idx_reg, rd_idx_next;   // next address issued
    logic [LW-1:0] got_reg, got_next;         // bytes taken into word
    logic          pend_reg, pend_next;       // read in flight
    logic [63:0]   word_reg, word_next;
    logic [NW-1:0] n_reg, n_next;
    logic          ov_reg, ov_next;           // output word register full
    logic [63:0]   ow_reg, ow_next;
    logic [3:0]    ob_reg, ob_next;
    logic          ol_reg, ol_next;
    logic [1:0]    ok_reg, ok_next;
    logic [2:0]    omt_reg, omt_next;
    logic [3:0]    ogid_reg, ogid_next;
    logic [5:0]    ooid_reg, ooid_next;
    logic [7:0]    otl_reg, otl_next;
    logic [LW-1:0] tot_reg, tot_next;
    logic          fire;
    logic [SW-1:0] sh;

    assign rd_addr = rd_idx_reg[AW-1:0];
    assign busy = (state_reg != ucfr_pkg::EM_IDLE) || ov_reg;
    assign fire = ov_reg && m_tready;
    assign sh = n_reg[SW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ucfr_pkg::EM_IDLE;
            ov_reg    <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            pend_reg  <= pend_next;
        end
        rd_idx_reg <= rd_idx_next;
        got_reg    <= got_next;
        word_reg   <= word_next;
        n_reg      <= n_next;
        ow_reg     <= ow_next;
        ob_reg     <= ob_next;
        ol_reg     <= ol_next;
        ok_reg     <= ok_next;
        omt_reg    <= omt_next;
        ogid_reg   <= ogid_next;
        ooid_reg   <= ooid_next;
        otl_reg    <= otl_next;
        tot_reg    <= tot_next;
    end

    always_comb begin
        state_next  = state_reg;
        rd_idx_next = rd_idx_reg;
        got_next    = got_reg;
        pend_next   = 1'b0;
        word_next   = word_reg;
        n_next      = n_reg;
        ov_next     = ov_reg && !m_tready;
        ow_next     = ow_reg;
        ob_next     = ob_reg;
        ol_next     = ol_reg;
        ok_next     = ok_reg;
        omt_next    = omt_reg;
        ogid_next   = ogid_reg;
        ooid_next   = ooid_reg;
        otl_next    = otl_reg;
        tot_next    = tot_reg;
        case (state_reg)
            ucfr_pkg::EM_IDLE: begin
                if (req.start) begin
                    state_next  = ucfr_pkg::EM_HEADER;
                    tot_next    = total;
                    omt_next    = req.msg_type;
                    ogid_next   = req.grp;
                    ooid_next   = req.opc;
                    rd_idx_next = '0;
                    got_next    = '0;
                    n_next      = '0;
                    word_next   = '0;
                end
            end
            ucfr_pkg::EM_HEADER: begin
                if (!ov_reg || m_tready) begin
                    ov_next   = 1'b1;
                    ok_next   = ucfr_pkg::KIND_HEADER;
                    ow_next   = '0;
                    ob_next   = '0;
                    ol_next   = (tot_reg == '0);
                    otl_next  = tot_reg[7:0];
                    state_next = (tot_reg == '0) ? ucfr_pkg::EM_IDLE : ucfr_pkg::EM_WORDS;
                end
            end
            ucfr_pkg::EM_WORDS: begin
                // one read at a time: a new byte is read only once the last has been taken into
                // the word, and a full word waits until the output word register has drained
                if (pend_reg) begin
                    word_next = word_reg | ({56'd0, rd_data} << {sh, 3'b000});
                    n_next    = n_reg + NW'(1);
                    got_next  = got_reg + LW'(1);
                end
                if (!pend_reg && (got_reg == tot_reg) && (n_reg == '0)) begin
                    state_next = ucfr_pkg::EM_IDLE;
                end else if (!pend_reg && ((n_reg == NW'(WB)) ||
                             ((got_reg == tot_reg) && (n_reg != '0)))) begin
                    if (!ov_reg || m_tready) begin
                        ov_next   = 1'b1;
                        ok_next   = ucfr_pkg::KIND_WORD;
                        ow_next   = word_reg;
                        ob_next   = 4'(n_reg);
                        ol_next   = (got_reg == tot_reg);
                        otl_next  = '0;
                        word_next = '0;
                        n_next    = '0;
                        if (got_reg == tot_reg) state_next = ucfr_pkg::EM_IDLE;
                    end
                end else if (!pend_reg && (rd_idx_reg != tot_reg)) begin
                    pend_next   = 1'b1;
                    rd_idx_next = rd_idx_reg + LW'(1);
                end
            end
            default: state_next = ucfr_pkg::EM_IDLE;
        endcase
    end

    assign m_tvalid = ov_reg;
    assign m_tlast  = ol_reg;
    assign m_tuser  = ok_reg;
    // tdata fields from bit 0: status, message type, group, opcode,
    // packet length, payload word, byte count
    always_comb begin
        m_tdata = '0;
        m_tdata[2:0]   = 3'(ucfr_pkg::ST_BUFFERED);
        m_tdata[5:3]   = (ok_reg == ucfr_pkg::KIND_HEADER) ? omt_reg : 3'd0;
        m_tdata[9:6]   = (ok_reg == ucfr_pkg::KIND_HEADER) ? ogid_reg : 4'd0;
        m_tdata[15:10] = (ok_reg == ucfr_pkg::KIND_HEADER) ? ooid_reg : 6'd0;
        m_tdata[23:16] = otl_reg;
        m_tdata[87:24] = ow_reg;
        m_tdata[91:88] = ob_reg;
    end

    logic unused_fire;
    assign unused_fire = fire;
endmodule
`default_nettype wire

// File: hdl/uwb_control_fragment_reassembler_top.sv
// Control packet fragment reassembler: top level.
// Data bytes are taken one per cycle while no status word or packet is outstanding.
// After a header the input stalls until its status word has been taken by the
// receiver. Bytes go into a 1-port-write/1-port-read byte memory; after the final
// byte of an accepted packet the input stalls while the emitter sends a header
// word and then ceil(total/WORD_BYTES) payload words. Each byte is read from the
// single read port one at a time (address, then registered data), and any
// receiver stall holds the output.
// The payload memory needs no clearing after reset.
`default_nettype none
module uwb_control_fragment_reassembler_top #(
    parameter int STORE_DEPTH = 1024,
    parameter int WORD_BYTES  = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: msg_type, group, opcode, declared_len, received_len,
    // data_byte, zero pad
    input  wire logic [39:0] s_tdata,
    input  wire logic        s_tlast,  // more_follow
    input  wire logic        s_tuser,  // op
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata: status, out message type, out group, out opcode, packet length,
    // payload_word, word_bytes, zero pad
    output logic [95:0]      m_tdata,
    output logic [1:0]       m_tuser,  // kind
    output logic             m_tlast
);
    localparam int AW = $clog2(STORE_DEPTH);
    localparam int LW = $clog2(STORE_DEPTH) + 1;

    logic [2:0] mt;
    logic [3:0] gid;
    logic [5:0] oid;
    logic [7:0] dlen;
    logic [8:0] rlen;
    logic [7:0] dbyte;
    assign mt    = s_tdata[2:0];
    assign gid   = s_tdata[6:3];
    assign oid   = s_tdata[12:7];
    assign dlen  = s_tdata[20:13];
    assign rlen  = s_tdata[29:21];
    assign dbyte = s_tdata[37:30];

    logic [7:0]    maxlen_reg;
    logic          active_reg, active_next;
    logic [2:0]    hmt_reg, hmt_next;
    logic [3:0]    hgid_reg, hgid_next;
    logic [5:0]    hoid_reg, hoid_next;
    logic [LW-1:0] blen_reg, blen_next;
    logic [7:0]    left_reg, left_next;
    ucfr_pkg::mode_t mode_reg, mode_next;

    // status word register
    logic          sv_reg, sv_next;
    logic [2:0]    sc_reg, sc_next;
    logic          sl_reg, sl_next;

    ucfr_pkg::emit_req_t req;
    logic          em_busy;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic          wr_en;
    logic          em_valid, em_last;
    logic [95:0]   em_data;
    logic [1:0]    em_user;
    logic          acc, same;
    logic [LW:0]   sum;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) maxlen_reg <= 8'd255;
        else if (cfg_valid) maxlen_reg <= cfg_data;
    end

    // stall while a status word or packet is still outstanding; a packet
    // started at an accepting edge shows as busy from the next cycle
    assign s_tready = !sv_reg && !em_busy;
    assign acc  = s_tvalid && s_tready;
    assign same = (hmt_reg == mt) && (hgid_reg == gid) && (hoid_reg == oid);
    assign wr_en = acc && s_tuser && (left_reg != 8'd0) &&
                   ((mode_reg == ucfr_pkg::MODE_CONT) || (mode_reg == ucfr_pkg::MODE_FINAL)) &&
                   (blen_reg < LW'(STORE_DEPTH));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            hmt_reg    <= '0;
            hgid_reg   <= '0;
            hoid_reg   <= '0;
            blen_reg   <= '0;
            left_reg   <= '0;
            mode_reg   <= ucfr_pkg::MODE_IDLE;
            sv_reg     <= 1'b0;
        end else begin
            active_reg <= active_next;
            hmt_reg    <= hmt_next;
            hgid_reg   <= hgid_next;
            hoid_reg   <= hoid_next;
            blen_reg   <= blen_next;
            left_reg   <= left_next;
            mode_reg   <= mode_next;
            sv_reg     <= sv_next;
        end
        sc_reg <= sc_next;
        sl_reg <= sl_next;
    end

    always_comb begin
        active_next = active_reg;
        hmt_next = hmt_reg;
        hgid_next = hgid_reg;
        hoid_next = hoid_reg;
        blen_next = blen_reg;
        left_next = left_reg;
        mode_next = mode_reg;
        // the status word has priority on the output
        sv_next = sv_reg && !m_tready;
        sc_next = sc_reg;
        sl_next = sl_reg;
        req.start = 1'b0;
        req.msg_type = hmt_reg;
        req.grp = hgid_reg;
        req.opc = hoid_reg;
        sum = '0;
        if (acc && s_tuser) begin
            if (mode_reg != ucfr_pkg::MODE_IDLE && left_reg != 8'd0) begin
                if (wr_en) blen_next = blen_reg + LW'(1);
                left_next = left_reg - 8'd1;
                if (left_reg == 8'd1) begin
                    mode_next = ucfr_pkg::MODE_IDLE;
                    if (mode_reg == ucfr_pkg::MODE_FINAL) req.start = 1'b1;
                end
            end
        end else if (acc) begin
            mode_next = ucfr_pkg::MODE_IDLE;
            left_next = 8'd0;
            sv_next = 1'b1;
            sl_next = 1'b1;
            if ({1'b0, rlen} < 10'(ucfr_pkg::HDR_BYTES) + {2'b0, dlen}) begin
                sc_next = 3'(ucfr_pkg::ST_SHORT);
            end else if (s_tlast) begin
                if (!active_reg || !same) begin
                    active_next = 1'b1;
                    hmt_next = mt; hgid_next = gid; hoid_next = oid;
                    sum = (LW+1)'(dlen);
                end else begin
                    sum = {1'b0, blen_reg} + (LW+1)'(dlen);
                end
                if (!active_reg || !same) blen_next = '0;
                if (sum > (LW+1)'(STORE_DEPTH)) begin
                    active_next = 1'b0;
                    blen_next = '0;
                    mode_next = ucfr_pkg::MODE_DROP;
                    left_next = dlen;
                    sc_next = 3'(ucfr_pkg::ST_OVERFLOW);
                end else begin
                    mode_next = (dlen == 8'd0) ? ucfr_pkg::MODE_IDLE : ucfr_pkg::MODE_CONT;
                    left_next = dlen;
                    sc_next = 3'(ucfr_pkg::ST_BUFFERED);
                end
            end else begin
                sum = {1'b0, blen_reg} + (LW+1)'(dlen);
                sc_next = 3'(ucfr_pkg::ST_ACCEPTED);
                if (active_reg && (!same || sum > (LW+1)'(STORE_DEPTH) ||
                                   sum > (LW+1)'(maxlen_reg))) begin
                    if (!same) sc_next = 3'(ucfr_pkg::ST_MISMATCH);
                    else if (sum > (LW+1)'(STORE_DEPTH)) sc_next = 3'(ucfr_pkg::ST_OVERFLOW);
                    else sc_next = 3'(ucfr_pkg::ST_TOO_LONG);
                    active_next = 1'b0;
                    blen_next = '0;
                    mode_next = (dlen == 8'd0) ? ucfr_pkg::MODE_IDLE : ucfr_pkg::MODE_DROP;
                    left_next = dlen;
                end else begin
                    if (!active_reg) begin
                        hmt_next = mt; hgid_next = gid; hoid_next = oid;
                        blen_next = '0;
                    end
                    if (dlen == 8'd0) begin
                        sl_next = 1'b0;
                        req.start = 1'b1;
                        req.msg_type = active_reg ? hmt_reg : mt;
                        req.grp = active_reg ? hgid_reg : gid;
                        req.opc = active_reg ? hoid_reg : oid;
                    end else begin
                        mode_next = ucfr_pkg::MODE_FINAL;
                        left_next = dlen;
                    end
                end
            end
        end
        if (req.start && s_tuser) begin
            // packet goes out: assembly closes
            active_next = 1'b0;
            blen_next = '0;
        end else if (req.start) begin
            active_next = 1'b0;
            blen_next = '0;
        end
    end

    logic [LW-1:0] em_total;
    assign em_total = (acc && !s_tuser) ? (active_reg ? blen_reg : '0)
                                        : (wr_en ? blen_reg + LW'(1) : blen_reg);

    ucfr_store #(.DEPTH(STORE_DEPTH), .AW(AW)) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (blen_reg[AW-1:0]),
        .wr_data (dbyte),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // emitter holds its words until the status word has gone
    logic em_ready;
    assign em_ready = m_tready && !sv_reg;

    ucfr_emitter #(.AW(AW), .LW(LW), .WB(WORD_BYTES), .TDW(96)) u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (req),
        .total    (em_total),
        .busy     (em_busy),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .m_tvalid (em_valid),
        .m_tready (em_ready),
        .m_tdata  (em_data),
        .m_tuser  (em_user),
        .m_tlast  (em_last)
    );

    always_comb begin
        if (sv_reg) begin
            m_tvalid = 1'b1;
            m_tdata  = '0;
            m_tdata[2:0] = sc_reg;
            m_tuser  = 2'(ucfr_pkg::KIND_STATUS);
            m_tlast  = sl_reg;
        end else begin
            m_tvalid = em_valid;
            m_tdata  = em_data;
            m_tuser  = em_user;
            m_tlast  = em_last;
        end
    end

    logic unused_in;
    assign unused_in = s_tdata[38] ^ s_tdata[39];
endmodule
`default_nettype wire

// File: tb/sv/ucfr_checker.sv
// Checker for the fragment reassembler: predicts every result word and compares it on arrival.
`timescale 1ns / 1ps
module ucfr_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [39:0] s_tdata,
    input  wire logic        s_tlast,
    input  wire logic        s_tuser,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [95:0] m_tdata,
    input  wire logic [1:0]  m_tuser,
    input  wire logic        m_tlast,
    output int               errors,
    output int               pending,
    output int               n_results
);
    localparam int DEPTH = 1024;
    localparam int WB    = 8;

    typedef struct packed {
        logic [95:0] data;
        logic [1:0]  kind;
        logic        last;
    } result_t;

    result_t     expected_q[$];

    logic [7:0]  limit_len;
    logic        asm_open;
    logic [2:0]  held_mt;
    logic [3:0]  held_gid;
    logic [5:0]  held_oid;
    logic [10:0] buf_len;
    logic [7:0]  byte_store [DEPTH];
    logic [7:0]  left_cnt;
    ucfr_pkg::mode_t mode;

    task automatic report_mismatch(string msg);
        $display("checker: word %0d: %s", n_results, msg);
        errors++;
    endtask

    task automatic push_result(ucfr_pkg::kind_t k, ucfr_pkg::status_t st, logic [2:0] mt,
                               logic [3:0] gid, logic [5:0] oid, logic [7:0] tl,
                               logic [63:0] w, logic [3:0] nb, logic lst);
        result_t r;
        r.data = {4'b0000, nb, w, tl, oid, gid, mt, st};
        r.kind = k;
        r.last = lst;
        expected_q.push_back(r);
    endtask

    task automatic push_status(ucfr_pkg::status_t st, logic lst);
        push_result(ucfr_pkg::KIND_STATUS, st, 3'd0, 4'd0, 6'd0, 8'd0, 64'd0, 4'd0, lst);
    endtask

    task automatic send_packet();
        int total;
        int i;
        int n;
        logic [63:0] w;
        total = buf_len;
        push_result(ucfr_pkg::KIND_HEADER, ucfr_pkg::ST_BUFFERED, held_mt, held_gid, held_oid,
                    total[7:0], 64'd0, 4'd0, total == 0);
        i = 0;
        while (i < total) begin
            w = 0;
            n = 0;
            while (n < WB && i < total) begin
                w[8*n +: 8] = byte_store[i];
                n++;
                i++;
            end
            push_result(ucfr_pkg::KIND_WORD, ucfr_pkg::ST_BUFFERED, 3'd0, 4'd0, 6'd0, 8'd0,
                        w, n[3:0], i >= total);
        end
        asm_open = 0;
        buf_len  = 0;
        mode     = ucfr_pkg::MODE_IDLE;
        left_cnt = 0;
    endtask

    task automatic take_fragment_item(logic op, logic [2:0] mt, logic more, logic [3:0] gid,
                                      logic [5:0] oid, logic [7:0] dlen, logic [8:0] rlen,
                                      logic [7:0] b);
        logic              same;
        ucfr_pkg::status_t code;
        if (op) begin
            if (mode == ucfr_pkg::MODE_IDLE || left_cnt == 0) return;
            if ((mode == ucfr_pkg::MODE_CONT || mode == ucfr_pkg::MODE_FINAL) &&
                buf_len < DEPTH) begin
                byte_store[buf_len] = b;
                buf_len++;
            end
            left_cnt--;
            if (left_cnt == 0) begin
                if (mode == ucfr_pkg::MODE_FINAL) send_packet();
                else mode = ucfr_pkg::MODE_IDLE;
            end
            return;
        end
        // a header ends any collection in progress
        mode     = ucfr_pkg::MODE_IDLE;
        left_cnt = 0;
        if (rlen < ucfr_pkg::HDR_BYTES + dlen) begin
            push_status(ucfr_pkg::ST_SHORT, 1'b1);
            return;
        end
        same = held_mt == mt && held_gid == gid && held_oid == oid;
        if (more) begin
            if (!asm_open || !same) begin
                asm_open = 1;
                held_mt  = mt;
                held_gid = gid;
                held_oid = oid;
                buf_len  = 0;
            end
            if (buf_len + dlen > DEPTH) begin
                asm_open = 0;
                buf_len  = 0;
                mode     = ucfr_pkg::MODE_DROP;
                left_cnt = dlen;
                push_status(ucfr_pkg::ST_OVERFLOW, 1'b1);
                return;
            end
            mode     = (dlen == 0) ? ucfr_pkg::MODE_IDLE : ucfr_pkg::MODE_CONT;
            left_cnt = dlen;
            push_status(ucfr_pkg::ST_BUFFERED, 1'b1);
            return;
        end
        if (asm_open) begin
            code = ucfr_pkg::ST_BUFFERED;
            if (!same) code = ucfr_pkg::ST_MISMATCH;
            else if (buf_len + dlen > DEPTH) code = ucfr_pkg::ST_OVERFLOW;
            else if (buf_len + dlen > limit_len) code = ucfr_pkg::ST_TOO_LONG;
            if (code != ucfr_pkg::ST_BUFFERED) begin
                asm_open = 0;
                buf_len  = 0;
                mode     = (dlen == 0) ? ucfr_pkg::MODE_IDLE : ucfr_pkg::MODE_DROP;
                left_cnt = dlen;
                push_status(code, 1'b1);
                return;
            end
        end else begin
            held_mt  = mt;
            held_gid = gid;
            held_oid = oid;
            buf_len  = 0;
        end
        if (dlen == 0) begin
            push_status(ucfr_pkg::ST_ACCEPTED, 1'b0);
            send_packet();
            return;
        end
        mode     = ucfr_pkg::MODE_FINAL;
        left_cnt = dlen;
        push_status(ucfr_pkg::ST_ACCEPTED, 1'b1);
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    initial begin
        errors    = 0;
        n_results = 0;
        pending   = 0;
    end

    always @(posedge aclk) begin
        result_t w;
        if (!aresetn) begin
            limit_len = 8'd255;
            asm_open  = 0;
            held_mt   = 0;
            held_gid  = 0;
            held_oid  = 0;
            buf_len   = 0;
            left_cnt  = 0;
            mode      = ucfr_pkg::MODE_IDLE;
            expected_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) limit_len = cfg_data;
            if (s_tvalid && s_tready)
                take_fragment_item(s_tuser, s_tdata[2:0], s_tlast, s_tdata[6:3],
                                   s_tdata[12:7], s_tdata[20:13], s_tdata[29:21],
                                   s_tdata[37:30]);
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected word");
                end else begin
                    w = expected_q.pop_front();
                    check_field("kind", m_tuser, w.kind);
                    check_field("status", m_tdata[2:0], w.data[2:0]);
                    check_field("msg_type", m_tdata[5:3], w.data[5:3]);
                    check_field("group", m_tdata[9:6], w.data[9:6]);
                    check_field("opcode", m_tdata[15:10], w.data[15:10]);
                    check_field("pkt_len", m_tdata[23:16], w.data[23:16]);
                    check_field("payload", m_tdata[87:24], w.data[87:24]);
                    check_field("word_bytes", m_tdata[91:88], w.data[91:88]);
                    check_field("pad", m_tdata[95:92], w.data[95:92]);
                    check_field("last", m_tlast, w.last);
                end
                n_results++;
            end
        end
        pending = expected_q.size();
    end
endmodule

// File: tb/sv/tb.sv
// Testbench top: drives fragments and register writes into the reassembler, gives the verdict.
`timescale 1ns / 1ps
module tb;
    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tlast = 0;
    logic        s_tuser = 0;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [95:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int errors, pending, n_results;
    int send_pct = 0;
    int stall_pct = 0;
    int hold_req = 0;
    int items_sent = 0;
    int packets = 0;

    always #5 aclk = ~aclk;

    uwb_control_fragment_reassembler_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tlast(s_tlast), .s_tuser(s_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    ucfr_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tlast(s_tlast), .s_tuser(s_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .errors(errors), .pending(pending), .n_results(n_results)
    );

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        int hold_cnt;
        hold_cnt = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_cnt = 400;
                hold_req = 0;
            end
            if (hold_cnt > 0) begin
                m_tready = 0;
                hold_cnt--;
            end else begin
                m_tready = ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin
        #20ms;
        $display("tb: timeout");
        $display("tb: done, errors");
        $finish;
    end

    // one word on the input; called and left at a falling edge
    task automatic push_word(logic op, logic [2:0] mt, logic more, logic [3:0] gid,
                             logic [5:0] oid, logic [7:0] dlen, logic [8:0] rlen,
                             logic [7:0] b);
        while ($urandom_range(99) < send_pct) begin
            s_tvalid = 0;
            @(negedge aclk);
        end
        s_tdata  = {2'b00, b, rlen, dlen, oid, gid, mt};
        s_tlast  = more;
        s_tuser  = op;
        s_tvalid = 1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic push_bytes(int n);
        repeat (n) push_word(1'b1, 3'($urandom), 1'($urandom), 4'($urandom), 6'($urandom),
                             8'($urandom), 9'($urandom), 8'($urandom));
    endtask

    task automatic push_frag(logic more, logic [2:0] mt, logic [3:0] gid, logic [5:0] oid,
                             int dlen, int rlen, int nbytes);
        push_word(1'b0, mt, more, gid, oid, dlen[7:0], rlen[8:0], 8'($urandom));
        push_bytes(nbytes);
    endtask

    task automatic write_limit(logic [7:0] v);
        cfg_data  = v;
        cfg_valid = 1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 0;
    endtask

    task automatic drain();
        s_tvalid = 0;
        while (pending != 0) @(negedge aclk);
        repeat (30) @(negedge aclk);
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 85) return $urandom_range(0, 12);
        if (r < 97) return $urandom_range(13, 40);
        return $urandom_range(41, 64);
    endfunction

    function automatic int good_rlen(int dlen);
        int r;
        r = 4 + dlen + $urandom_range(0, 3);
        return (r > 259) ? 259 : r;
    endfunction

    task automatic random_sequence();
        int r, nfrag, dlen;
        logic [2:0] mt;
        logic [3:0] gid;
        logic [5:0] oid;
        r   = $urandom_range(99);
        mt  = 3'($urandom);
        gid = 4'($urandom);
        oid = 6'($urandom);
        dlen = pick_len();
        if (r < 70) begin
            nfrag = $urandom_range(1, 3);
            for (int f = 0; f < nfrag; f++) begin
                if ($urandom_range(9) == 0) oid = oid ^ 6'd1;
                push_frag(f < nfrag - 1, mt, gid, oid, dlen, good_rlen(dlen), dlen);
                dlen = pick_len();
            end
            packets++;
        end else if (r < 78) begin
            push_frag(1'($urandom), mt, gid, oid, dlen, $urandom_range(0, 3 + dlen),
                      $urandom_range(0, dlen));
        end else if (r < 86) begin
            // cut short by the next header
            push_frag(1'($urandom), mt, gid, oid, dlen, good_rlen(dlen),
                      (dlen == 0) ? 0 : $urandom_range(0, dlen - 1));
        end else if (r < 92) begin
            if (pending == 0) push_bytes($urandom_range(1, 3));
        end else begin
            push_frag(1'($urandom), mt, gid, oid, dlen, $urandom_range(0, 259),
                      $urandom_range(0, dlen));
        end
    endtask

    initial begin
        logic [7:0] limits [4];
        int pct_s [4];
        int pct_r [4];
        int quota;
        limits[0] = 8'd255; limits[1] = 8'd1;
        limits[2] = 8'($urandom_range(2, 254)); limits[3] = 8'd16;
        pct_s = '{0, 77, 0, 35};
        pct_r = '{0, 0, 77, 35};

        repeat (9) @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);

        // directed part, register at its reset value
        push_frag(1'b0, 3'd0, 4'd0, 6'd0, 0, 4, 0);           // zero-length final
        push_frag(1'b0, 3'd7, 4'd15, 6'd63, 1, 5, 1);         // single byte, top ids
        push_frag(1'b0, 3'd1, 4'd2, 6'd3, 2, 0, 2);           // short
        push_bytes(2);                                        // data while idle
        push_frag(1'b1, 3'd5, 4'd9, 6'd33, 4, 9, 4);
        push_frag(1'b0, 3'd5, 4'd9, 6'd33, 5, 9, 5);          // nine bytes, two words
        push_frag(1'b1, 3'd2, 4'd4, 6'd8, 3, 7, 3);
        push_frag(1'b0, 3'd2, 4'd5, 6'd8, 2, 6, 2);           // mismatch on final
        push_frag(1'b1, 3'd6, 4'd1, 6'd2, 10, 14, 10);
        push_frag(1'b0, 3'd6, 4'd1, 6'd2, 9, 13, 9);          // nineteen bytes, three words
        push_frag(1'b0, 3'd4, 4'd3, 6'd7, 6, 10, 3);          // interrupted final
        drain();

        for (int p = 0; p < 4; p++) begin
            write_limit(limits[p]);
            send_pct  = pct_s[p];
            stall_pct = pct_r[p];
            if (p == 0) hold_req = 1;
            quota = items_sent + 38;
            while (items_sent < quota) random_sequence();
            drain();
        end
        write_limit(8'd255);

        $display("tb: %0d input words, %0d result words, %0d well-formed packets tried",
                 items_sent, n_results, packets);
        $display("tb: limits 255, 1, %0d and 16 over four idle/stall phases", limits[2]);
        if (errors == 0 && pending == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule
